// File: hw/rtl/olid_pkg.sv
package olid_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths of the words on the ports
    localparam int FUNC_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 5;
    localparam int OUT_DATA_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [IDX_W:0]     DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0]   IDX_TOP = IDX_W'(DEPTH - 1);

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_INS_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INS_BACK  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE    = 2'd2;
    localparam logic [FUNC_W-1:0] OP_DISPLAY   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] data;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic                  last;
    } result_t;

    // Physical slot of logical offset ofs in the ring that starts at head
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] ofs);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot in front of head, wrapping round the ring
    function automatic logic [IDX_W-1:0] prev_addr(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] res;
        if (head == '0) begin
            res = IDX_TOP;
        end else begin
            res = head - 1'b1;
        end
        return res;
    endfunction

    // Stored width to output field width
    function automatic logic [OUT_DATA_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] wide;
        wide = 64'(d);
        return wide[OUT_DATA_W-1:0];
    endfunction

endpackage

// File: hw/rtl/olid_ram.sv
module olid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/olid_ctrl.sv
module olid_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request side
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [olid_pkg::FUNC_W-1:0]         req_func,
    input  logic [olid_pkg::VALUE_W-1:0]        req_value,
    input  logic [olid_pkg::POS_W-1:0]          req_pos,
    // result side
    input  logic                                out_free,
    output logic                                res_valid,
    output olid_pkg::result_t                   res,
    // element store
    output logic                                wr_en,
    output logic [olid_pkg::IDX_W-1:0]          wr_addr,
    output logic [olid_pkg::DATA_WIDTH-1:0]     wr_data,
    output logic                                rd_en,
    output logic [olid_pkg::IDX_W-1:0]          rd_addr,
    input  logic [olid_pkg::DATA_WIDTH-1:0]     rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DEL   = 3'd2;
    localparam logic [2:0] S_DDONE = 3'd3;
    localparam logic [2:0] S_DREQ  = 3'd4;
    localparam logic [2:0] S_DWAIT = 3'd5;

    logic [2:0]                          state_reg,   state_next;
    logic [olid_pkg::FUNC_W-1:0]         func_reg,    func_next;
    logic [olid_pkg::DATA_WIDTH-1:0]     value_reg,   value_next;
    logic [olid_pkg::POS_W-1:0]          pos_reg,     pos_next;
    logic [olid_pkg::IDX_W-1:0]          head_reg,    head_next;
    logic [olid_pkg::CNT_W-1:0]          len_reg,     len_next;
    logic [olid_pkg::IDX_W-1:0]          idx_reg,     idx_next;
    logic [olid_pkg::IDX_W-1:0]          k_reg,       k_next;
    logic [olid_pkg::DATA_WIDTH-1:0]     removed_reg, removed_next;

    logic full;
    logic bad_pos;

    assign full    = (len_reg >= olid_pkg::DEPTH_C);
    assign bad_pos = (len_reg == '0) || (pos_reg == '0) || (int'(pos_reg) > int'(len_reg));
    assign req_ready = (state_reg == S_IDLE);

    // Sequence one operation through the store
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        head_next    = head_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        removed_next = removed_reg;
        res_valid    = 1'b0;
        res          = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = value_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    func_next  = req_func;
                    value_next = olid_pkg::DATA_WIDTH'(req_value);
                    pos_next   = req_pos;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                case (func_reg) inside
                    olid_pkg::OP_INS_FRONT, olid_pkg::OP_INS_BACK: begin
                        if (out_free) begin
                            res_valid   = 1'b1;
                            res.data    = olid_pkg::to_out(value_reg);
                            res.last    = 1'b1;
                            state_next  = S_IDLE;
                            if (full) begin
                                res.status = olid_pkg::ST_FULL;
                                res.count  = olid_pkg::COUNT_W'(len_reg);
                            end else begin
                                wr_en = 1'b1;
                                if (func_reg == olid_pkg::OP_INS_FRONT) begin
                                    wr_addr   = olid_pkg::prev_addr(head_reg);
                                    head_next = olid_pkg::prev_addr(head_reg);
                                end else begin
                                    wr_addr = olid_pkg::phys_addr(head_reg,
                                                  olid_pkg::IDX_W'(len_reg));
                                end
                                len_next   = len_reg + 1'b1;
                                res.status = olid_pkg::ST_OK;
                                res.count  = olid_pkg::COUNT_W'(len_reg + 1'b1);
                            end
                        end
                    end
                    olid_pkg::OP_DELETE: begin
                        if (bad_pos) begin
                            if (out_free) begin
                                res_valid  = 1'b1;
                                res.status = olid_pkg::ST_BAD;
                                res.count  = olid_pkg::COUNT_W'(len_reg);
                                res.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end else begin
                            // fetch the victim first, then pull the tail forward
                            k_next     = olid_pkg::IDX_W'(pos_reg - 1'b1);
                            idx_next   = olid_pkg::IDX_W'(pos_reg - 1'b1);
                            rd_en      = 1'b1;
                            rd_addr    = olid_pkg::phys_addr(head_reg,
                                             olid_pkg::IDX_W'(pos_reg - 1'b1));
                            state_next = S_DEL;
                        end
                    end
                    default: begin
                        if (len_reg == '0) begin
                            if (out_free) begin
                                res_valid  = 1'b1;
                                res.status = olid_pkg::ST_BAD;
                                res.last   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end else begin
                            idx_next   = '0;
                            state_next = S_DREQ;
                        end
                    end
                endcase
            end

            S_DEL: begin
                // rd_data holds the element at offset idx_reg
                if (idx_reg == k_reg) begin
                    removed_next = rd_data;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = olid_pkg::phys_addr(head_reg, idx_reg - 1'b1);
                    wr_data = rd_data;
                end
                if (int'(idx_reg) + 1 < int'(len_reg)) begin
                    rd_en    = 1'b1;
                    rd_addr  = olid_pkg::phys_addr(head_reg, idx_reg + 1'b1);
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = S_DDONE;
                end
            end

            S_DDONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    res.data   = olid_pkg::to_out(removed_reg);
                    res.status = olid_pkg::ST_OK;
                    res.count  = olid_pkg::COUNT_W'(len_reg - 1'b1);
                    res.last   = 1'b1;
                    len_next   = len_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DREQ: begin
                // read only when the output register will be empty next cycle
                if (out_free) begin
                    rd_en      = 1'b1;
                    rd_addr    = olid_pkg::phys_addr(head_reg, idx_reg);
                    state_next = S_DWAIT;
                end
            end

            S_DWAIT: begin
                res_valid  = 1'b1;
                res.data   = olid_pkg::to_out(rd_data);
                res.status = olid_pkg::ST_OK;
                res.count  = olid_pkg::COUNT_W'(len_reg);
                res.last   = (int'(idx_reg) + 1 == int'(len_reg));
                if (int'(idx_reg) + 1 == int'(len_reg)) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DREQ;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            len_reg   <= len_next;
        end
    end

    // Operands and working registers
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        removed_reg <= removed_next;
    end

    // A result is only offered when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result offered while output register busy");

    // Never hold more elements than slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= olid_pkg::DEPTH_C)
        else $error("element count above depth");

    // Gap closing never reads and writes the same slot in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write collide on one slot");

    // A completed delete drops the count by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DDONE && out_free) |=> (len_reg == $past(len_reg) - 1'b1))
        else $error("delete did not shrink the list by one");

endmodule

// File: hw/rtl/ordered_list_insert_delete.sv
// Ordered list of signed 32-bit values held in a ring buffer memory.
// Input words (s_*) carry one operation each: the opcode in s_tuser, the
// value and 1-based position in s_tdata. Result words (m_*) carry the data,
// status and element count after the operation; m_tlast marks the final
// result caused by an input word.
// Inserts at either end and failed requests produce one result from the
// execute state that follows acceptance. A delete reads the victim and moves
// every later element one slot forward, one element a cycle through the
// single memory write port. Display reads the memory once per element and
// loads each into the output register, reading only when it will be free.
// One word is worked on at a time; s_tready is high only while the block
// is idle, so the next word can be taken in the cycle after the last
// result is loaded. A stalled m_tready holds the output register and
// pauses the sequencer before each result; the delete shift does not wait.
// After reset the list is empty; stored slots need no clearing pass.
module ordered_list_insert_delete (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], status[33:32], count[38:34], zero pad
    output logic        m_tlast
);

    logic                                res_valid;
    olid_pkg::result_t                   res;
    logic                                out_free;
    logic                                wr_en;
    logic [olid_pkg::IDX_W-1:0]          wr_addr;
    logic [olid_pkg::DATA_WIDTH-1:0]     wr_data;
    logic                                rd_en;
    logic [olid_pkg::IDX_W-1:0]          rd_addr;
    logic [olid_pkg::DATA_WIDTH-1:0]     rd_data;

    logic              m_valid_reg, m_valid_next;
    olid_pkg::result_t m_res_reg,   m_res_next;

    assign out_free = !m_valid_reg || m_tready;

    olid_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_func  (s_tuser),
        .req_value (s_tdata[31:0]),
        .req_pos   (s_tdata[36:32]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    olid_ram #(
        .WIDTH (olid_pkg::DATA_WIDTH),
        .DEPTH (olid_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Load a new result or drop the one taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.count, m_res_reg.status, m_res_reg.data};
    assign m_tlast  = m_res_reg.last;

endmodule

// File: dv/ordered_list_insert_delete_tb.sv
module ordered_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 64;     // longer than a full delete or display
    localparam int RANDOM_OPS   = 333;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic [olid_pkg::FUNC_W-1:0]         func;
        logic signed [olid_pkg::VALUE_W-1:0] value;
        logic [olid_pkg::POS_W-1:0]          pos;
        int                                  phase;
    } list_op_t;

    // Idle and stall percentages per phase
    int unsigned tx_gap_pct   [3] = '{18, 80, 0};
    int unsigned rx_stall_pct [3] = '{80, 18, 0};

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], position[36:32], zero pad
    logic [1:0]  s_tuser  = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // data[31:0], status[33:32], count[38:34], zero pad
    logic        m_tlast;

    // Stimulus and scoreboard state
    list_op_t                            pending_ops [$];
    list_op_t                            cur_op;
    olid_pkg::result_t                   expected_results [$];
    logic signed [olid_pkg::VALUE_W-1:0] list_cells [olid_pkg::DEPTH];
    int                                  list_len;
    int                                  plan_len;
    int                                  cur_phase;
    int                                  n_planned;
    int                                  n_accepted;
    int                                  n_results;
    int                                  n_displays;
    int                                  n_full_inserts;
    int                                  n_bad_deletes;
    int                                  mismatches;
    int                                  quiet_cycles;
    logic                                timed_out;

    ordered_list_insert_delete uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Print one line per mismatch, up to a cap, and count them all
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    // Queue one operation, tracking the list length the stimulus expects
    task automatic plan_op(input logic [olid_pkg::FUNC_W-1:0] func,
                           input logic signed [31:0] value, input int pos);
        list_op_t op;
        op.func  = func;
        op.value = value;
        op.pos   = olid_pkg::POS_W'(pos);
        op.phase = (n_planned < 120) ? 0 : (n_planned < 240) ? 1 : 2;
        pending_ops.push_back(op);
        n_planned++;
        if ((func == olid_pkg::OP_INS_FRONT || func == olid_pkg::OP_INS_BACK) &&
            plan_len < olid_pkg::DEPTH) begin
            plan_len++;
        end else if (func == olid_pkg::OP_DELETE && pos >= 1 && pos <= plan_len) begin
            plan_len--;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 19))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = -32'sd1;
            3:       v = 32'sd0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void push_expected(input logic [31:0] data,
                                          input logic [olid_pkg::STATUS_W-1:0] status,
                                          input logic last);
        olid_pkg::result_t r;
        r.data   = data;
        r.status = status;
        r.count  = olid_pkg::COUNT_W'(list_len);
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list and queue its results
    function automatic void apply_list_op(input list_op_t op);
        int k;
        case (op.func) inside
            olid_pkg::OP_INS_FRONT, olid_pkg::OP_INS_BACK: begin
                if (list_len >= olid_pkg::DEPTH) begin
                    n_full_inserts++;
                    push_expected(op.value, olid_pkg::ST_FULL, 1'b1);
                end else begin
                    if (op.func == olid_pkg::OP_INS_FRONT) begin
                        for (k = list_len; k > 0; k--) begin
                            list_cells[k] = list_cells[k-1];
                        end
                        list_cells[0] = op.value;
                    end else begin
                        list_cells[list_len] = op.value;
                    end
                    list_len++;
                    push_expected(op.value, olid_pkg::ST_OK, 1'b1);
                end
            end
            olid_pkg::OP_DELETE: begin
                if (list_len == 0 || op.pos == 0 || int'(op.pos) > list_len) begin
                    n_bad_deletes++;
                    push_expected('0, olid_pkg::ST_BAD, 1'b1);
                end else begin
                    logic signed [31:0] removed;
                    removed = list_cells[op.pos-1];
                    for (k = op.pos - 1; k + 1 < list_len; k++) begin
                        list_cells[k] = list_cells[k+1];
                    end
                    list_len--;
                    push_expected(removed, olid_pkg::ST_OK, 1'b1);
                end
            end
            default: begin
                n_displays++;
                if (list_len == 0) begin
                    push_expected('0, olid_pkg::ST_BAD, 1'b1);
                end else begin
                    for (k = 0; k < list_len; k++) begin
                        push_expected(list_cells[k], olid_pkg::ST_OK, k == list_len - 1);
                    end
                end
            end
        endcase
    endfunction

    // Driver: present queued operations, holding each word until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_list_op(cur_op);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 &&
                    $urandom_range(0, 99) >= tx_gap_pct[pending_ops[0].phase]) begin
                    cur_op = pending_ops.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {3'b000, cur_op.pos, cur_op.value};
                    s_tuser   <= cur_op.func;
                    cur_phase <= cur_op.phase;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest expectation
    always @(posedge aclk) begin
        olid_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result word, tdata %h", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.data) begin
                        flag_mismatch($sformatf("data %h, want %h", m_tdata[31:0], want.data));
                    end
                    if (m_tdata[33:32] !== want.status) begin
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                m_tdata[33:32], want.status));
                    end
                    if (m_tdata[38:34] !== want.count) begin
                        flag_mismatch($sformatf("count %0d, want %0d",
                                                m_tdata[38:34], want.count));
                    end
                    if (m_tlast !== want.last) begin
                        flag_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct[cur_phase]);
        end
    end

    // Watchdog: count cycles in which no word moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            timed_out <= 1'b1;
        end
    end

    initial begin
        @(posedge timed_out);
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int i;
        int r;
        int k;
        bit filling;
        list_len       = 0;
        plan_len       = 0;
        cur_phase      = 0;
        n_planned      = 0;
        n_accepted     = 0;
        n_results      = 0;
        n_displays     = 0;
        n_full_inserts = 0;
        n_bad_deletes  = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        timed_out      = 1'b0;
        filling        = 1'b1;

        // Directed: empty list, only element, bad positions, full list
        plan_op(olid_pkg::OP_DISPLAY, 32'sd0, 0);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, 1);
        plan_op(olid_pkg::OP_INS_BACK, 32'sd5, 0);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, 1);
        plan_op(olid_pkg::OP_INS_FRONT, 32'sh8000_0000, 0);
        plan_op(olid_pkg::OP_INS_BACK, 32'sh7fff_ffff, 0);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, 0);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, 3);
        for (k = 0; k < olid_pkg::DEPTH - 2; k++) begin
            plan_op((k % 2 == 0) ? olid_pkg::OP_INS_FRONT : olid_pkg::OP_INS_BACK,
                    pick_value(), 0);
        end
        plan_op(olid_pkg::OP_INS_FRONT, 32'sh1234_5678, 0);
        plan_op(olid_pkg::OP_INS_BACK, -32'sd7, 0);
        plan_op(olid_pkg::OP_DISPLAY, 32'sd0, 0);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, olid_pkg::DEPTH);
        plan_op(olid_pkg::OP_DELETE, 32'sd0, 1);

        // Random: bursts that grow or shrink the list, mostly valid positions
        for (i = 0; i < RANDOM_OPS; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                filling = !filling;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                plan_op(olid_pkg::OP_DISPLAY, pick_value(), $urandom_range(0, 31));
            end else if (r < (filling ? 75 : 35)) begin
                plan_op($urandom_range(0, 1) ? olid_pkg::OP_INS_FRONT : olid_pkg::OP_INS_BACK,
                        pick_value(), $urandom_range(0, 31));
            end else if (plan_len > 0 && $urandom_range(0, 99) < 85) begin
                plan_op(olid_pkg::OP_DELETE, pick_value(), $urandom_range(1, plan_len));
            end else begin
                plan_op(olid_pkg::OP_DELETE, pick_value(), $urandom_range(0, 31));
            end
        end

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every operation to be taken and every result to arrive
        while (n_accepted < n_planned || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operations: %0d displays, %0d inserts on a full list,",
                 n_accepted, n_displays, n_full_inserts);
        $display("%0d bad deletes; checked %0d result words under three stall mixes",
                 n_bad_deletes, n_results);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/olid_pkg.sv
hw/rtl/olid_ram.sv
hw/rtl/olid_ctrl.sv
hw/rtl/ordered_list_insert_delete.sv
dv/ordered_list_insert_delete_tb.sv
